// ===== rtl/core/xcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// xcpd_pkg
// Shared constants and types for the XOR-checked packet deframer.
// ----------------------------------------------------------------------------
package xcpd_pkg;

  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_HUNT1   = 3'd0;
  localparam logic [PhaseW-1:0] PH_HUNT2   = 3'd1;
  localparam logic [PhaseW-1:0] PH_TYPE    = 3'd2;
  localparam logic [PhaseW-1:0] PH_LENGTH  = 3'd3;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PhaseW-1:0] PH_CHECK   = 3'd5;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2
  } event_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_FIRST_HEADER  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_HEADER = 1'd1;

  localparam logic [7:0] FIRST_HEADER_RST  = 8'd170;
  localparam logic [7:0] SECOND_HEADER_RST = 8'd85;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
  } res_t;

endpackage

// ===== rtl/core/xcpd_in_if.sv =====
// ----------------------------------------------------------------------------
// xcpd_in_if
// Received-byte channel: valid/ready handshake with byte and buffer-end flag.
// ----------------------------------------------------------------------------
interface xcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ===== rtl/core/xcpd_out_if.sv =====
// ----------------------------------------------------------------------------
// xcpd_out_if
// Event channel: valid/ready handshake with one payload or frame-end event.
// ----------------------------------------------------------------------------
interface xcpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [7:0] byte_index;
  logic [7:0] payload_byte;

  modport source (output valid, output event_res, output frame_type,
                  output frame_length, output byte_index, output payload_byte,
                  input ready);
  modport sink   (input valid, input event_res, input frame_type,
                  input frame_length, input byte_index, input payload_byte,
                  output ready);
endinterface

// ===== rtl/core/xcpd_fsm.sv =====
// ----------------------------------------------------------------------------
// xcpd_fsm
// Frame parser: header hunt, type/length capture, payload count, XOR check.
// ----------------------------------------------------------------------------
module xcpd_fsm
  import xcpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_end_i,
  input  logic [7:0] first_header_i,
  input  logic [7:0] second_header_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        length_q, length_d;
  logic [7:0]        count_q, count_d;
  logic [7:0]        xor_q, xor_d;

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    length_d    = length_q;
    count_d     = count_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o.event_res    = EV_PAYLOAD;
    res_o.frame_type   = type_q;
    res_o.frame_length = length_q;
    res_o.byte_index   = count_q;
    res_o.payload_byte = rx_byte_i;

    case (phase_q)
      PH_HUNT1: begin
        if (rx_byte_i == first_header_i) phase_d = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (rx_byte_i == second_header_i)     phase_d = PH_TYPE;
        else if (rx_byte_i == first_header_i) phase_d = PH_HUNT2;
        else                                  phase_d = PH_HUNT1;
      end
      PH_TYPE: begin
        type_d  = rx_byte_i;
        xor_d   = rx_byte_i;
        phase_d = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_d = rx_byte_i;
        xor_d    = xor_q ^ rx_byte_i;
        count_d  = 8'd0;
        phase_d  = (rx_byte_i == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_valid_o = 1'b1;
        xor_d       = xor_q ^ rx_byte_i;
        count_d     = count_q + 8'd1;
        if (count_d == length_q) phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        res_valid_o        = 1'b1;
        res_o.event_res    = (rx_byte_i == xor_q) ? EV_GOOD : EV_BAD;
        res_o.byte_index   = 8'd0;
        res_o.payload_byte = 8'd0;
        phase_d            = PH_HUNT1;
      end
      default: begin
        phase_d = PH_HUNT1;
      end
    endcase

    if (buffer_end_i) phase_d = PH_HUNT1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      type_q   <= 8'd0;
      length_q <= 8'd0;
      count_q  <= 8'd0;
      xor_q    <= 8'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      length_q <= length_d;
      count_q  <= count_d;
      xor_q    <= xor_d;
    end
  end

endmodule

// ===== rtl/core/xor_checked_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer_unit
// Hunts for a two-byte header, then type, length, payload and an XOR checksum.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while input ready is high; each transaction
// updates the parser state in the cycle it is accepted and its event, if
// any, appears in the output register on the next cycle. Input ready stays
// high unless the output register holds an event that is not being taken.
// Payload bytes produce an event with their index; the checksum byte
// produces a good/bad verdict. A byte flagged buffer_end is processed and
// then drops any frame in progress. Header bytes are written through the
// cfg port (index 0 first header, 1 second header) and should only be
// changed while the block is idle.
module xor_checked_packet_deframer_unit
  import xcpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  xcpd_in_if.sink             rx_i,
  xcpd_out_if.source          ev_o
);

  logic [7:0] first_hdr_q, second_hdr_q;
  logic       accept;
  logic       res_valid;
  res_t       res;
  logic       out_valid_q;
  res_t       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_hdr_q  <= FIRST_HEADER_RST;
      second_hdr_q <= SECOND_HEADER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_HEADER:  first_hdr_q  <= cfg_data_i;
        REG_SECOND_HEADER: second_hdr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rx_i.ready = !out_valid_q || ev_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  xcpd_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_i.rx_byte),
    .buffer_end_i    (rx_i.buffer_end),
    .first_header_i  (first_hdr_q),
    .second_header_i (second_hdr_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      out_valid_q <= accept && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign ev_o.valid        = out_valid_q;
  assign ev_o.event_res    = out_q.event_res;
  assign ev_o.frame_type   = out_q.frame_type;
  assign ev_o.frame_length = out_q.frame_length;
  assign ev_o.byte_index   = out_q.byte_index;
  assign ev_o.payload_byte = out_q.payload_byte;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR-checked packet deframer. Streams directed
// and randomized frames under several header settings, predicts every
// payload and verdict event in a scoreboard and compares each event as it
// is accepted, with bursty input and a stalling event sink.
// ----------------------------------------------------------------------------
module tb
  import xcpd_pkg::*;
();

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned PhaseLen  = 170;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  class deframe_scoreboard;
    logic [7:0]        hdr_first;
    logic [7:0]        hdr_second;
    logic [PhaseW-1:0] phase;
    logic [7:0]        cur_type;
    logic [7:0]        cur_len;
    logic [7:0]        pay_cnt;
    logic [7:0]        chk_xor;
    res_t              event_q[$];
    int                errors;

    function new();
      hdr_first  = FIRST_HEADER_RST;
      hdr_second = SECOND_HEADER_RST;
      phase      = PH_HUNT1;
      cur_type   = '0;
      cur_len    = '0;
      pay_cnt    = '0;
      chk_xor    = '0;
      errors     = 0;
    endfunction

    function void set_header(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      if (idx == REG_FIRST_HEADER) begin
        hdr_first = val;
      end else begin
        hdr_second = val;
      end
    endfunction

    function int pending();
      return event_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      res_t ev;
      ev = '0;
      ev.frame_type   = cur_type;
      ev.frame_length = cur_len;
      case (phase)
        PH_HUNT1: begin
          if (b == hdr_first) phase = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (b == hdr_second) begin
            phase = PH_TYPE;
          end else if (b != hdr_first) begin
            phase = PH_HUNT1;
          end
        end
        PH_TYPE: begin
          cur_type = b;
          chk_xor  = b;
          phase    = PH_LENGTH;
        end
        PH_LENGTH: begin
          cur_len = b;
          chk_xor = chk_xor ^ b;
          pay_cnt = '0;
          phase   = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          ev.event_res    = EV_PAYLOAD;
          ev.byte_index   = pay_cnt;
          ev.payload_byte = b;
          event_q.push_back(ev);
          chk_xor = chk_xor ^ b;
          pay_cnt = pay_cnt + 8'd1;
          if (pay_cnt == cur_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          ev.event_res = (b == chk_xor) ? EV_GOOD : EV_BAD;
          event_q.push_back(ev);
          phase = PH_HUNT1;
        end
        default: begin
          phase = PH_HUNT1;
        end
      endcase
      if (last) phase = PH_HUNT1;
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_event(res_t got);
      res_t want;
      if (event_q.size() == 0) begin
        $error("event with none pending: event_res %0d byte_index %0d", got.event_res,
               got.byte_index);
        errors++;
        return;
      end
      want = event_q.pop_front();
      cmp_field("event_res", 8'(want.event_res), 8'(got.event_res));
      cmp_field("frame_type", want.frame_type, got.frame_type);
      cmp_field("frame_length", want.frame_length, got.frame_length);
      cmp_field("byte_index", want.byte_index, got.byte_index);
      cmp_field("payload_byte", want.payload_byte, got.payload_byte);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  xcpd_in_if  rx_if ();
  xcpd_out_if ev_if ();

  xor_checked_packet_deframer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .ev_o       (ev_if)
  );

  deframe_scoreboard sb;
  rx_item_t          stim_q[$];
  int                hold_cycles;
  int                drain_pause_at;
  int unsigned       idle_cycles;
  res_t              got_ev;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Transaction monitor and watchdog.
  always @(posedge clk_i) begin
    if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte, rx_if.buffer_end);
    if (ev_if.valid && ev_if.ready) begin
      got_ev.event_res    = ev_if.event_res;
      got_ev.frame_type   = ev_if.frame_type;
      got_ev.frame_length = ev_if.frame_length;
      got_ev.byte_index   = ev_if.byte_index;
      got_ev.payload_byte = ev_if.payload_byte;
      sb.check_event(got_ev);
    end
    if (rx_if.valid && rx_if.ready || ev_if.valid && ev_if.ready || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Event sink: random stall patterns in segments, plus an occasional long hold.
  initial begin
    int mode;
    int seg_left;
    int unsigned cyc;
    mode     = 0;
    seg_left = 0;
    cyc      = 0;
    ev_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_cycles > 0) begin
        ev_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 96);
        end
        seg_left--;
        case (mode)
          0: ev_if.ready <= 1'b1;
          1: ev_if.ready <= 1'($urandom_range(0, 1));
          2: ev_if.ready <= ($urandom_range(0, 3) != 0);
          default: ev_if.ready <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  task automatic push_byte(logic [7:0] data, logic last);
    rx_item_t it;
    it.data = data;
    it.last = last;
    stim_q.push_back(it);
  endtask

  task automatic build_traffic(int n_items, logic [7:0] h1, logic [7:0] h2);
    int         roll;
    int         len;
    int         cut;
    logic [7:0] x;
    logic [7:0] fr[$];
    logic       last;
    while (stim_q.size() < n_items) begin
      roll = $urandom_range(0, 99);
      fr.delete();
      if (roll < 12) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)),
                                                $urandom_range(0, 15) == 0);
      end else if (roll < 18) begin
        push_byte(h1, 1'b0);
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        len = $urandom_range(0, 99);
        if (len < 10) begin
          len = 0;
        end else if (len < 13) begin
          len = $urandom_range(200, 255);
        end else begin
          len = $urandom_range(1, 12);
        end
        fr.push_back(h1);
        if (h1 != h2 && $urandom_range(0, 7) == 0) fr.push_back(h1);
        fr.push_back(h2);
        x = 8'($urandom_range(0, 255));
        fr.push_back(x);
        fr.push_back(8'(len));
        x = x ^ 8'(len);
        repeat (len) begin
          fr.push_back(8'($urandom_range(0, 255)));
          x = x ^ fr[$];
        end
        if ($urandom_range(0, 3) == 0) x = x ^ 8'($urandom_range(1, 255));
        fr.push_back(x);
        cut = (roll < 24) ? $urandom_range(1, fr.size() - 1) : fr.size();
        for (int i = 0; i < cut; i++) begin
          last = ($urandom_range(0, 99) == 0);
          if (i == cut - 1) begin
            if (cut < fr.size()) begin
              last = last || ($urandom_range(0, 4) != 0);
            end else begin
              last = last || ($urandom_range(0, 9) == 0);
            end
          end
          push_byte(fr[i], last);
        end
      end
    end
  endtask

  // Drives stim_q in bursts; called at a falling edge, returns at one.
  task automatic send_bytes();
    int burst_left;
    int gap;
    int sent;
    burst_left = 0;
    sent       = 0;
    while (stim_q.size() > 0) begin
      if (sent == drain_pause_at) begin
        rx_if.valid <= 1'b0;
        @(negedge clk_i);
        while (sb.pending() != 0) @(negedge clk_i);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          rx_if.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      rx_if.valid      <= 1'b1;
      rx_if.rx_byte    <= stim_q[0].data;
      rx_if.buffer_end <= stim_q[0].last;
      do @(posedge clk_i); while (!rx_if.ready);
      void'(stim_q.pop_front());
      sent++;
      if (burst_left > 0) burst_left--;
      @(negedge clk_i);
    end
    rx_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_header(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] h1;
    logic [7:0] h2;
    sb             = new();
    hold_cycles    = 0;
    drain_pause_at = -1;
    idle_cycles    = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    rx_if.buffer_end = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Repeated first header, zero length, good checksum.
    push_byte(8'hAA, 1'b0); push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    // One payload byte of 0xFF, bad checksum.
    push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    // Second header mismatch.
    push_byte(8'hAA, 1'b0); push_byte(8'h13, 1'b0);
    // Buffer end on a payload byte drops the frame.
    push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0); push_byte(8'h07, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b1);
    // Buffer end on the checksum byte keeps the verdict.
    push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b1);
    // Buffer end on a header match.
    push_byte(8'hAA, 1'b1);
    send_bytes();
    settle();

    // Reset headers under back-pressure and a full drain pause.
    build_traffic(PhaseLen, FIRST_HEADER_RST, SECOND_HEADER_RST);
    hold_cycles    = LongHold;
    drain_pause_at = PhaseLen / 2;
    send_bytes();
    drain_pause_at = -1;
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin h1 = 8'h00; h2 = 8'hFF; end
        1: begin h1 = 8'hFF; h2 = 8'h00; end
        2: begin h1 = 8'h5A; h2 = 8'h5A; end
        3: begin h1 = 8'h00; h2 = 8'h00; end
        default: begin
          h1 = 8'($urandom_range(0, 255));
          h2 = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_FIRST_HEADER, h1);
      write_reg(REG_SECOND_HEADER, h2);
      build_traffic(PhaseLen, h1, h2);
      send_bytes();
      settle();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
